// ----- hw/rtl/plc_pkg.sv -----
// types, constants and codes shared by the piecewise linear calibration block
package plc_pkg;

   localparam int SEGMENTS  = 16;
   localparam int SEG_IDX_W = $clog2(SEGMENTS);
   localparam int SEG_CNT_W = $clog2(SEGMENTS + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_DEFINED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_IN_USE  = 1'd1;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   // product, quotient and interpolation widths
   localparam int PROD_W  = 64;
   localparam int QUO_W   = 33;
   localparam int BASE_W  = 35;
   localparam int DIV_STEPS = QUO_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_UNDEF  = 2'd1,
      STAT_NO_SEG = 2'd2,
      STAT_ZERO_W = 2'd3
   } status_type;

   typedef struct packed {
      logic                      func;
      logic [3:0]                segment_index;
      logic signed [31:0]        seg_low_raw;
      logic signed [31:0]        seg_high_raw;
      logic signed [31:0]        seg_low_eng;
      logic signed [31:0]        seg_high_eng;
      logic signed [31:0]        raw_sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0]        eng_value;
      status_type                status;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0]        low_raw;
      logic signed [31:0]        upper_raw;
      logic signed [31:0]        low_eng;
      logic signed [31:0]        upper_eng;
   } seg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_CHECK,
      ST_PREP,
      ST_ABS,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_SAT,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/plc_seg_mem.sv -----
// segment table memory, one write port and one registered read port
module plc_seg_mem
   import plc_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SEG_IDX_W-1:0] wr_addr,
   input  seg_type              wr_data,
   input  logic [SEG_IDX_W-1:0] rd_addr,
   output seg_type              rd_data
);

   seg_type mem [SEGMENTS];
   seg_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/plc_mul.sv -----
// 32 x 33 unsigned multiplier built from two 16-bit partial products
module plc_mul
   import plc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       a,
   input  logic [32:0]       b,
   output logic              done,
   output logic [PROD_W-1:0] prod
);

   logic [31:0]       a_ff;
   logic [32:0]       b_ff;
   logic [48:0]       pp_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [1:0]        step_ff;
   logic [1:0]        step_in;
   logic              run_ff;
   logic              run_in;
   logic              done_ff;
   logic              done_in;
   logic [15:0]       a_half;

   assign a_half = (step_ff == 2'd0) ? a_ff[15:0] : a_ff[31:16];

   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = 2'd0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end else if (run_ff) begin
         case (step_ff)
            2'd0: begin
               pp_ff <= a_half * b_ff;
            end
            2'd1: begin
               acc_ff <= {15'd0, pp_ff};
               pp_ff  <= a_half * b_ff;
            end
            default: begin
               acc_ff <= acc_ff + {pp_ff[47:0], 16'd0};
            end
         endcase
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- hw/rtl/plc_div.sv -----
// restoring divider, one quotient bit a cycle; quotient known to fit 33 bits
module plc_div
   import plc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] num,
   input  logic [31:0]       den,
   output logic              done,
   output logic [QUO_W-1:0]  quo,
   output logic              rem_nz
);

   logic [31:0]          rem_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [31:0]          den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic                 run_ff;
   logic                 run_in;
   logic                 done_ff;
   logic                 done_in;
   logic [32:0]          shifted;
   logic [33:0]          diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = ~diff[33];

   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         run_in = 1'b1;
      end else if (run_ff) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // high numerator bits start as the partial remainder, already below den
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num[PROD_W-1:QUO_W]};
         quo_ff <= num[QUO_W-1:0];
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[31:0] : shifted[31:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign done   = done_ff;
   assign quo    = quo_ff;
   assign rem_nz = |rem_ff;

endmodule

// ----- hw/rtl/piecewise_linear_calibration_top.sv -----
// top level of the piecewise linear calibration block: control and datapath
//
// Converts signed raw telemetry to signed Q16.16 engineering units through a
// table of up to 16 segments held in a single-port-write, registered-read
// memory. A write item (func 0) stores one segment and answers 0 / ok.
// A convert item (func 1) scans slots 0 to segments_in_use-1 in order,
// each slot through an address state, then a registered-data state, and
// takes the first slot whose raw bounds hold the sample. A zero-width
// covering segment answers with its zero-width status; any other goes
// through offset and slope prep, a 32x33 multiply as two 16-bit partial
// products, a restoring divider giving one quotient bit a cycle and
// rounding toward zero plus saturation. The divider takes the largest share
// of a conversion. Undefined calibration or an empty table answers without
// a scan. One item is in work at a time; the result sits in an output
// register, so a new item is taken while it waits. The user must write config
// registers via csr_we / csr_index / csr_wdata only while idle; not enforced.
module piecewise_linear_calibration_top
   import plc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // config registers
   logic                 cal_defined_ff;
   logic [SEG_CNT_W-1:0] seg_in_use_ff;
   logic [SEG_CNT_W-1:0] n_eff;

   // control
   state_type            state_ff;
   state_type            state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   // datapath registers
   req_type              req_ff;
   req_type              req_in;
   logic [SEG_CNT_W-1:0] idx_ff;
   logic [SEG_CNT_W-1:0] idx_in;
   seg_type              seg_ff;
   seg_type              seg_in;
   logic [31:0]          dr_ff;
   logic [31:0]          dr_in;
   logic [31:0]          off_ff;
   logic [31:0]          off_in;
   logic signed [32:0]   de_ff;
   logic signed [32:0]   de_in;
   logic                 neg_ff;
   logic                 neg_in;
   logic signed [BASE_W-1:0] base_ff;
   logic signed [BASE_W-1:0] base_in;
   logic signed [BASE_W-1:0] adj_ff;
   logic signed [BASE_W-1:0] adj_in;
   logic signed [31:0]   eng_ff;
   logic signed [31:0]   eng_in;
   status_type           stat_ff;
   status_type           stat_in;
   rsp_type              rsp_ff;

   // memory and units
   logic                 mem_we;
   seg_type              mem_rd;
   logic                 mul_start;
   logic                 mul_done;
   logic [PROD_W-1:0]    mul_prod;
   logic [32:0]          mag;
   logic                 div_start;
   logic                 div_done;
   logic [QUO_W-1:0]     div_quo;
   logic                 div_rem_nz;

   // helpers
   logic                 covers;
   logic [SEG_CNT_W-1:0] idx_next;
   logic                 out_load;
   logic signed [32:0]   dr_full;
   logic signed [32:0]   off_full;
   logic signed [BASE_W-1:0] le_ext;
   logic signed [BASE_W-1:0] q_ext;

   localparam logic signed [BASE_W-1:0] ENG_MAX = BASE_W'(64'sd2147483647);
   localparam logic signed [BASE_W-1:0] ENG_MIN = BASE_W'(-64'sd2147483648);

   // a count beyond the table is clamped to the table size
   assign n_eff = (seg_in_use_ff > SEG_CNT_W'(SEGMENTS)) ? SEG_CNT_W'(SEGMENTS)
                                                          : seg_in_use_ff;

   assign covers   = (mem_rd.low_raw <= req_ff.raw_sample) &&
                     (req_ff.raw_sample <= mem_rd.upper_raw);
   assign idx_next = idx_ff + SEG_CNT_W'(1);

   assign dr_full  = {seg_ff.upper_raw[31], seg_ff.upper_raw} -
                     {seg_ff.low_raw[31], seg_ff.low_raw};
   assign off_full = {req_ff.raw_sample[31], req_ff.raw_sample} -
                     {seg_ff.low_raw[31], seg_ff.low_raw};
   assign mag      = de_ff[32] ? 33'(-de_ff) : 33'(de_ff);
   assign le_ext   = BASE_W'(seg_ff.low_eng);
   assign q_ext    = BASE_W'({2'b00, div_quo});

   plc_seg_mem u_seg_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (req_ff.segment_index),
      .wr_data ({req_ff.seg_low_raw, req_ff.seg_high_raw,
                 req_ff.seg_low_eng, req_ff.seg_high_eng}),
      .rd_addr (idx_ff[SEG_IDX_W-1:0]),
      .rd_data (mem_rd)
   );

   plc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (off_ff),
      .b     (mag),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   plc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (mul_prod),
      .den    (dr_ff),
      .done   (div_done),
      .quo    (div_quo),
      .rem_nz (div_rem_nz)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_WRITE) begin
                  state_in = ST_WRITE;
               end else if (!cal_defined_ff || n_eff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (covers) begin
               state_in = (mem_rd.low_raw == mem_rd.upper_raw) ? ST_DONE : ST_PREP;
            end else if (idx_next == n_eff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_PREP:  state_in = ST_ABS;
         ST_ABS:   state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:   state_in = ST_SAT;
         ST_SAT:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      req_in    = req_ff;
      idx_in    = idx_ff;
      seg_in    = seg_ff;
      dr_in     = dr_ff;
      off_in    = off_ff;
      de_in     = de_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      adj_in    = adj_ff;
      eng_in    = eng_ff;
      stat_in   = stat_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               eng_in = '0;
               // undefined calibration wins over an empty table
               if (req_data.func == FUNC_WRITE) begin
                  stat_in = STAT_OK;
               end else if (!cal_defined_ff) begin
                  stat_in = STAT_UNDEF;
               end else if (n_eff == '0) begin
                  stat_in = STAT_NO_SEG;
               end else begin
                  stat_in = STAT_OK;
               end
            end
         end
         ST_WRITE: begin
            mem_we = 1'b1;
         end
         ST_CHECK: begin
            if (covers) begin
               seg_in = mem_rd;
               if (mem_rd.low_raw == mem_rd.upper_raw) begin
                  stat_in = STAT_ZERO_W;
               end
            end else begin
               idx_in = idx_next;
               if (idx_next == n_eff) begin
                  stat_in = STAT_NO_SEG;
               end
            end
         end
         ST_PREP: begin
            dr_in  = dr_full[31:0];
            off_in = off_full[31:0];
            de_in  = {seg_ff.upper_eng[31], seg_ff.upper_eng} -
                     {seg_ff.low_eng[31], seg_ff.low_eng};
         end
         ST_ABS: begin
            neg_in    = de_ff[32];
            mul_start = 1'b1;
         end
         ST_MUL: begin
            div_start = mul_done;
         end
         ST_DIV: begin
            if (div_done) begin
               base_in = neg_ff ? (le_ext - q_ext) : (le_ext + q_ext);
            end
         end
         ST_FIX: begin
            // truncate toward zero when the division was inexact
            if (div_rem_nz && !neg_ff && base_ff < 0) begin
               adj_in = base_ff + BASE_W'(1);
            end else if (div_rem_nz && neg_ff && base_ff > 0) begin
               adj_in = base_ff - BASE_W'(1);
            end else begin
               adj_in = base_ff;
            end
         end
         ST_SAT: begin
            if (adj_ff > ENG_MAX) begin
               eng_in = 32'sh7fffffff;
            end else if (adj_ff < ENG_MIN) begin
               eng_in = 32'sh80000000;
            end else begin
               eng_in = adj_ff[31:0];
            end
         end
         ST_DONE: begin
            out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // output register valid: load wins, a taken item clears it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         cal_defined_ff <= 1'b0;
         seg_in_use_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CAL_DEFINED: cal_defined_ff <= csr_wdata[0];
               CSR_SEG_IN_USE:  seg_in_use_ff  <= csr_wdata[SEG_CNT_W-1:0];
               default:         cal_defined_ff <= cal_defined_ff;
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      seg_ff  <= seg_in;
      dr_ff   <= dr_in;
      off_ff  <= off_in;
      de_ff   <= de_in;
      neg_ff  <= neg_in;
      base_ff <= base_in;
      adj_ff  <= adj_in;
      eng_ff  <= eng_in;
      stat_ff <= stat_in;
      if (out_load) begin
         rsp_ff.eng_value <= eng_ff;
         rsp_ff.status    <= stat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- tb/plc_calibration_checker.sv -----
// scoreboard for the piecewise linear calibration block: predicts and checks every result item
module plc_calibration_checker
   import plc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,

   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   output int                    outstanding,
   output int                    failures
);
   timeunit 1ns;
   timeprecision 1ps;

   seg_type               cal_table [SEGMENTS];
   logic                  cal_on;
   logic [CSR_DATA_W-1:0] seg_count;
   rsp_type               expected_eng_q [$];

   // linear interpolation inside one segment, rounded toward zero, saturated to 32 bits
   function automatic logic signed [31:0] interpolate(longint raw, seg_type s);
      longint          lr, hr, le, he, de, base, res;
      longint unsigned span, offs, mag, num, quo, rem;
      bit              neg;
      lr   = $signed(s.low_raw);
      hr   = $signed(s.upper_raw);
      le   = $signed(s.low_eng);
      he   = $signed(s.upper_eng);
      span = hr - lr;
      offs = raw - lr;
      de   = he - le;
      neg  = de < 0;
      mag  = neg ? -de : de;
      num  = offs * mag;
      quo  = num / span;
      rem  = num % span;
      base = neg ? le - $signed(quo) : le + $signed(quo);
      res  = base;
      if (rem != 0) begin
         if (!neg && base < 0) begin
            res = base + 1;
         end else if (neg && base > 0) begin
            res = base - 1;
         end
      end
      if (res > 64'sd2147483647) begin
         res = 64'sd2147483647;
      end
      if (res < -64'sd2147483648) begin
         res = -64'sd2147483648;
      end
      return res[31:0];
   endfunction

   // result of one item; a segment write also updates the table copy
   function automatic rsp_type calibrate(req_type r);
      rsp_type o;
      longint  raw;
      int      n;
      bit      hit;
      o.eng_value = '0;
      o.status    = STAT_OK;
      hit         = 1'b0;
      raw         = $signed(r.raw_sample);
      if (r.func == FUNC_WRITE) begin
         cal_table[r.segment_index] = '{r.seg_low_raw, r.seg_high_raw,
                                        r.seg_low_eng, r.seg_high_eng};
      end else if (!cal_on) begin
         o.status = STAT_UNDEF;
      end else begin
         n = (seg_count > SEGMENTS) ? SEGMENTS : int'(seg_count);
         for (int i = 0; i < n && !hit; i++) begin
            if ($signed(cal_table[i].low_raw) <= raw &&
                raw <= $signed(cal_table[i].upper_raw)) begin
               hit = 1'b1;
               if (cal_table[i].low_raw == cal_table[i].upper_raw) begin
                  o.status = STAT_ZERO_W;
               end else begin
                  o.eng_value = interpolate(raw, cal_table[i]);
               end
            end
         end
         if (!hit) begin
            o.status = STAT_NO_SEG;
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cal_on    = 1'b0;
         seg_count = '0;
         failures  = 0;
         expected_eng_q.delete();
         for (int i = 0; i < SEGMENTS; i++) begin
            cal_table[i] = '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CAL_DEFINED) begin
               cal_on = csr_wdata[0];
            end else if (csr_index == CSR_SEG_IN_USE) begin
               seg_count = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            expected_eng_q.push_back(calibrate(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_eng_q.size() == 0) begin
               $error("unexpected result item: eng_value %0d status %0d",
                      rsp_data.eng_value, rsp_data.status);
               failures++;
            end else begin
               want = expected_eng_q.pop_front();
               if (rsp_data.eng_value !== want.eng_value) begin
                  $error("eng_value mismatch: expected %0d, actual %0d",
                         want.eng_value, rsp_data.eng_value);
                  failures++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  failures++;
               end
            end
         end
      end
      outstanding <= expected_eng_q.size();
   end

endmodule

// ----- tb/piecewise_linear_calibration_top_test.sv -----
// testbench top for the piecewise linear calibration block: stimulus, idling and verdict
module piecewise_linear_calibration_top_test
   import plc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   // the limit allows for a full conversion, long stalls and the pauses
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int END_PAUSE       = 100;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 95;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int results_outstanding;
   int check_failures;

   // idle percentages of the sender and the receiver
   int idle_pct  = 0;
   int stall_pct = 0;

   // raw bounds last written to each slot, used only to aim conversions
   longint aim_lo [SEGMENTS];
   longint aim_hi [SEGMENTS];

   int writes_sent   = 0;
   int converts_sent = 0;
   int quiet_cycles  = 0;

   // segment counts per random phase: empty, single, partial, full and over-range tables
   int count_plan [PHASES] = '{16, 1, 31, 0, 5, 17, 16, 2, 12, 16, 9, 16};

   piecewise_linear_calibration_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   plc_calibration_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (results_outstanding),
      .failures    (check_failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("piecewise_linear_calibration_top test failed");
         $finish;
      end
   end

   // offer one item after a random gap and hold it until accepted
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and wait until every expected result item is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
   endtask

   // both registers in back-to-back writes, only while idle
   task automatic program_regs(input logic cal, input logic [CSR_DATA_W-1:0] count);
      csr_we    <= 1'b1;
      csr_index <= CSR_CAL_DEFINED;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, cal};
      @(posedge clock);
      csr_index <= CSR_SEG_IN_USE;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // segment write; the unused raw_sample field carries noise
   task automatic send_write(input logic [3:0] idx,
                             input logic signed [31:0] lr, hr, le, he);
      req_type it;
      it.func          = FUNC_WRITE;
      it.segment_index = idx;
      it.seg_low_raw   = lr;
      it.seg_high_raw  = hr;
      it.seg_low_eng   = le;
      it.seg_high_eng  = he;
      it.raw_sample    = $urandom;
      aim_lo[idx]      = lr;
      aim_hi[idx]      = hr;
      writes_sent++;
      send_item(it);
   endtask

   // conversion; the unused segment fields carry noise
   task automatic send_convert(input logic signed [31:0] raw);
      req_type it;
      it.func          = FUNC_CONVERT;
      it.segment_index = 4'($urandom);
      it.seg_low_raw   = $urandom;
      it.seg_high_raw  = $urandom;
      it.seg_low_eng   = $urandom;
      it.seg_high_eng  = $urandom;
      it.raw_sample    = raw;
      converts_sent++;
      send_item(it);
   endtask

   // random segment: mostly well formed, some zero width, inverted, full range or noise
   task automatic send_random_write(input logic [3:0] idx);
      longint             lr, hr, w;
      logic signed [31:0] le, he;
      int                 shape, eng_kind;
      shape = $urandom_range(99);
      lr    = $signed($urandom);
      if (shape < 60) begin
         case ($urandom_range(2))
            0:       w = $urandom_range(64, 1);
            1:       w = $urandom_range(65536, 1);
            default: w = $urandom_range(32'h7fff_ffff, 1);
         endcase
         if (lr + w > S32_MAX) begin
            lr = S32_MAX - w;
         end
         hr = lr + w;
      end else if (shape < 70) begin
         hr = lr;
      end else if (shape < 80) begin
         if (lr < S32_MIN + 1000) begin
            lr = 0;
         end
         hr = lr - $urandom_range(1000, 1);
      end else if (shape < 88) begin
         lr = S32_MIN;
         hr = S32_MAX;
      end else begin
         hr = $signed($urandom);
      end
      // engineering ends: full-scale swings, small whole units or anything
      eng_kind = $urandom_range(9);
      if (eng_kind < 2) begin
         le = S32_MIN;
         he = S32_MAX;
         if ($urandom_range(1)) begin
            le = S32_MAX;
            he = S32_MIN;
         end
      end else if (eng_kind < 4) begin
         le = ($urandom_range(200) - 100) * 65536;
         he = ($urandom_range(200) - 100) * 65536;
      end else begin
         le = $urandom;
         he = $urandom;
      end
      send_write(idx, lr[31:0], hr[31:0], le, he);
   endtask

   initial begin
      logic            cal;
      int              count, n_eff, k, pick;
      longint          lo, hi, raw;
      longint unsigned span;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // calibration undefined with an empty table, raw extremes
      program_regs(1'b0, '0);
      send_convert(S32_MIN);
      send_convert(S32_MAX);
      // slot 0: bottom of the raw range with full-scale engineering swing
      send_write(4'd0, S32_MIN, S32_MIN + 1000, S32_MIN, S32_MAX);
      // slot 1: inverted bounds, covers nothing
      send_write(4'd1, 32'sd100, -32'sd100, 32'sd5, 32'sd6);
      // slot 2: zero width at raw 5
      send_write(4'd2, 32'sd5, 32'sd5, 32'sd65536, 32'sd131072);
      // slot 3: falling slope across zero, hit after the zero-width slot
      send_write(4'd3, -32'sd100, 32'sd100, S32_MAX, S32_MIN);
      // slot 4: whole raw range
      send_write(4'd4, S32_MIN, S32_MAX, -32'sd196608, 32'sd458752);
      // defined calibration but no segments in use
      drain_results();
      program_regs(1'b1, 5'd0);
      send_convert(32'sd0);
      // four slots: bounds, truncation, zero width, first slot wins, gaps
      drain_results();
      program_regs(1'b1, 5'd4);
      send_convert(S32_MIN);
      send_convert(S32_MIN + 1000);
      send_convert(S32_MIN + 333);
      send_convert(32'sd5);
      send_convert(-32'sd50);
      send_convert(-32'sd100);
      send_convert(32'sd100);
      send_convert(32'sd500);
      send_convert(S32_MAX);
      // whole-range slot covers the gaps and the top end
      drain_results();
      program_regs(1'b1, 5'd5);
      send_convert(32'sd500);
      send_convert(S32_MAX);
      send_convert(32'sd12345);
      // undefined again with segments in use
      drain_results();
      program_regs(1'b0, 5'd5);
      send_convert(32'sd500);

      // ---- fill every slot so any segment count is safe to scan ----
      for (int i = 0; i < SEGMENTS; i++) begin
         send_random_write(i[3:0]);
      end

      // ---- random phases over register settings and idle mixes ----
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 49; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         cal   = (p % 5 != 4);
         count = count_plan[p];
         program_regs(cal, count[CSR_DATA_W-1:0]);
         n_eff = (count > SEGMENTS) ? SEGMENTS : count;
         for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
            // sender holds off until the block has answered everything
            if (j % 50 == 49) begin
               drain_results();
            end
            if ($urandom_range(99) < 20) begin
               send_random_write(4'($urandom_range(SEGMENTS - 1)));
            end else begin
               pick = $urandom_range(99);
               k    = (n_eff > 0) ? $urandom_range(n_eff - 1) : 0;
               lo   = aim_lo[k];
               hi   = aim_hi[k];
               if (cal && n_eff > 0 && pick < 75) begin
                  // aim inside a slot in use
                  if (lo <= hi) begin
                     case ($urandom_range(3))
                        0:       raw = lo;
                        1:       raw = hi;
                        default: begin
                           span = hi - lo + 1;
                           raw  = lo + $signed({$urandom, $urandom} % span);
                        end
                     endcase
                  end else begin
                     raw = $urandom_range(1) ? lo : hi;
                  end
               end else if (pick < 85) begin
                  // just outside the bounds of some slot
                  k   = $urandom_range(SEGMENTS - 1);
                  raw = $urandom_range(1) ? aim_lo[k] - 1 : aim_hi[k] + 1;
               end else if (pick < 90) begin
                  raw = $urandom_range(1) ? S32_MIN : S32_MAX;
               end else begin
                  raw = $signed($urandom);
               end
               send_convert(raw[31:0]);
            end
         end
      end

      // ---- wind down: all results back, then a latency's worth of quiet ----
      drain_results();
      repeat (END_PAUSE) @(posedge clock);

      $display("covered %0d items: %0d segment writes, %0d conversions, %0d random phases",
               writes_sent + converts_sent, writes_sent, converts_sent, PHASES);
      $display("settings swept calibration on and off, empty, partial, full and over-range tables");
      if (check_failures == 0 && results_outstanding == 0) begin
         $display("piecewise_linear_calibration_top test passed");
      end else begin
         $display("piecewise_linear_calibration_top test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/plc_pkg.sv
hw/rtl/plc_seg_mem.sv
hw/rtl/plc_mul.sv
hw/rtl/plc_div.sv
hw/rtl/piecewise_linear_calibration_top.sv
tb/plc_calibration_checker.sv
tb/piecewise_linear_calibration_top_test.sv
